// ===== design/gme_pkg.sv =====
package gme_pkg;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 23;
  localparam int WSIZE_W    = 3;
  localparam int IWIDTH_W   = 11;
  localparam int CHAN_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int DEF_MAX_ORDER    = 7;
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_BYTES    = 4194304;
  localparam int DEF_STORE_DEPTH  = 32768;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_MIN = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OP_MODE,
    REG_WINDOW_SIZE,
    REG_IMAGE_WIDTH,
    REG_CHANNEL_COUNT,
    REG_TOTAL_BYTES
  } cfg_reg_e;

  typedef enum logic {
    OP_DILATE,
    OP_ERODE
  } op_mode_e;

  localparam op_mode_e               DEF_OP_MODE       = OP_DILATE;
  localparam logic [WSIZE_W-1:0]     DEF_WINDOW_SIZE   = 3'd3;
  localparam logic [IWIDTH_W-1:0]    DEF_IMAGE_WIDTH   = 11'd640;
  localparam logic [CHAN_W-1:0]      DEF_CHANNEL_COUNT = 3'd1;
  localparam logic [CNT_W-1:0]       DEF_TOTAL_BYTES   = 23'd307200;

  // one classified beat handed from front to back
  typedef struct packed {
    logic              wr;
    logic              emit;
    logic              last;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  wpos;
    logic [CNT_W-1:0]  xpos;
  } cmd_t;

  function automatic logic [BYTE_W-1:0] morph_ident(op_mode_e op);
    return (op == OP_ERODE) ? BYTE_MAX : BYTE_MIN;
  endfunction

  function automatic logic [BYTE_W-1:0] morph_pick(op_mode_e op, logic [BYTE_W-1:0] a,
                                                   logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    if (op == OP_ERODE) begin
      r = (b < a) ? b : a;
    end else begin
      r = (b > a) ? b : a;
    end
    return r;
  endfunction

endpackage

// ===== design/gme_cfg.sv =====
module gme_cfg
  import gme_pkg::*;
#(
  parameter int MAX_ORDER    = DEF_MAX_ORDER,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_BYTES    = DEF_MAX_BYTES,
  localparam int OW    = $clog2(MAX_ORDER + 1),
  localparam int WW    = $clog2(MAX_WIDTH + 1),
  localparam int CW    = $clog2(MAX_CHANNELS + 1),
  localparam int OFS_W = $clog2(MAX_ORDER * (MAX_WIDTH + 1) * MAX_CHANNELS + 1) + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic                    busy_o,
  output op_mode_e                op_o,
  output logic [OW-1:0]           order_o,
  output logic [CW-1:0]           chans_o,
  output logic [CNT_W-1:0]        total_o,
  output logic [OFS_W-1:0]        look_o,
  output logic [OFS_W-1:0]        prime_o,
  output logic signed [OFS_W-1:0] ro_o [MAX_ORDER],
  output logic signed [OFS_W-1:0] to_o [MAX_ORDER][MAX_ORDER]
);

  // cycles the input is held off while the derived offsets settle
  localparam int SETTLE = 2;

  op_mode_e              op_q;
  logic [WSIZE_W-1:0]    ws_q;
  logic [IWIDTH_W-1:0]   iw_q;
  logic [CHAN_W-1:0]     cc_q;
  logic [CNT_W-1:0]      tb_q;
  logic [1:0]            settle_q;

  logic [OW-1:0]         order_s;
  logic [OW-1:0]         hi_s;
  logic [WW-1:0]         width_s;
  logic [CW-1:0]         chans_s;
  logic [CNT_W-1:0]      total_s;

  logic [OFS_W-1:0]        hc_q;
  logic [OFS_W-1:0]        wc_q;
  logic signed [OW:0]      lo_q;
  logic [OFS_W-1:0]        prime_q;
  logic [OFS_W-1:0]        look_q;
  logic signed [OFS_W-1:0] ro_q [MAX_ORDER];
  logic signed [OFS_W-1:0] to_q [MAX_ORDER][MAX_ORDER];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= DEF_OP_MODE;
      ws_q <= DEF_WINDOW_SIZE;
      iw_q <= DEF_IMAGE_WIDTH;
      cc_q <= DEF_CHANNEL_COUNT;
      tb_q <= DEF_TOTAL_BYTES;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_OP_MODE:       op_q <= op_mode_e'(cfg_data_i[0]);
        REG_WINDOW_SIZE:   ws_q <= cfg_data_i[WSIZE_W-1:0];
        REG_IMAGE_WIDTH:   iw_q <= cfg_data_i[IWIDTH_W-1:0];
        REG_CHANNEL_COUNT: cc_q <= cfg_data_i[CHAN_W-1:0];
        REG_TOTAL_BYTES:   tb_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'(SETTLE);
    end else if (cfg_valid_i) begin
      settle_q <= 2'(SETTLE);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  assign busy_o = settle_q != '0;

  always_comb begin
    order_s = (int'(ws_q) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(ws_q);
    width_s = (int'(iw_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(iw_q);
    chans_s = (int'(cc_q) > MAX_CHANNELS) ? CW'(MAX_CHANNELS) : CW'(cc_q);
    total_s = (longint'(tb_q) > longint'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : tb_q;
    hi_s    = order_s >> 1;
  end

  // after a write: hc/wc/lo/prime, then look/ro, then to settle
  always_ff @(posedge clk_i) begin
    hc_q    <= OFS_W'(hi_s) * OFS_W'(chans_s);
    wc_q    <= OFS_W'(width_s) * OFS_W'(chans_s);
    lo_q    <= {1'b0, hi_s} - {1'b0, order_s} + 1'b1;
    prime_q <= (order_s == '0) ? '0 : OFS_W'(order_s - 1'b1) * OFS_W'(chans_s);
    look_q  <= hc_q * (OFS_W'(width_s) + 1'b1);
    for (int k = 0; k < MAX_ORDER; k++) begin
      ro_q[k] <= (OFS_W'(lo_q) + OFS_W'(k)) * $signed(wc_q) + $signed(hc_q);
    end
    for (int k = 0; k < MAX_ORDER; k++) begin
      for (int j = 0; j < MAX_ORDER; j++) begin
        to_q[k][j] <= ro_q[k] - $signed(OFS_W'(j) * OFS_W'(chans_s));
      end
    end
  end

  assign op_o    = op_q;
  assign order_o = order_s;
  assign chans_o = chans_s;
  assign total_o = total_s;
  assign look_o  = look_q;
  assign prime_o = prime_q;
  assign ro_o    = ro_q;
  assign to_o    = to_q;

endmodule

// ===== design/gme_front.sv =====
module gme_front
  import gme_pkg::*;
#(
  parameter int MAX_ORDER    = DEF_MAX_ORDER,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  localparam int OFS_W = $clog2(MAX_ORDER * (MAX_WIDTH + 1) * MAX_CHANNELS + 1) + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] sample_i,
  input  logic              pad_i,
  input  logic [CNT_W-1:0]  total_i,
  input  logic [OFS_W-1:0]  look_i,
  input  logic              cfg_busy_i,
  input  logic              queue_full_i,
  output logic              cmd_push_o,
  output cmd_t              cmd_o
);

  logic [CNT_W-1:0] rc_q, rc_d, em_q, em_d;
  logic [CNT_W-1:0] rc0, em0, rc1, em1;
  logic [CNT_W:0]   need, lim;
  logic             accept, restart, wr, emit, last;

  assign in_stall_o = queue_full_i || cfg_busy_i;

  always_comb begin
    accept  = in_valid_i && !in_stall_o;
    restart = em_q >= total_i;
    rc0     = restart ? '0 : rc_q;
    em0     = restart ? '0 : em_q;
    wr      = !pad_i && (rc0 < total_i);
    rc1     = rc0 + CNT_W'(wr);
    need    = {1'b0, em0} + (CNT_W + 1)'(look_i);
    lim     = {1'b0, total_i} - 1'b1;
    if (need > lim) begin
      need = lim;
    end
    // a result is due once its whole lookahead has arrived
    emit = (em0 < total_i) && ({1'b0, rc1} > need);
    last = em0 == (total_i - 1'b1);
    em1  = em0 + CNT_W'(emit);
    rc_d = rc_q;
    em_d = em_q;
    if (accept) begin
      if (emit && (em1 >= total_i)) begin
        rc_d = '0;
        em_d = '0;
      end else begin
        rc_d = rc1;
        em_d = em1;
      end
    end
    cmd_push_o = accept && (wr || emit);
    cmd_o = '{wr: wr, emit: emit, last: last, data: sample_i, wpos: rc0, xpos: em0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      em_q <= '0;
    end else begin
      rc_q <= rc_d;
      em_q <= em_d;
    end
  end

endmodule

// ===== design/gme_queue.sv =====
module gme_queue
  import gme_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     count_q;

  assign full_o  = count_q == (PW + 1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PW + 1)'(push_i) - (PW + 1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/gme_back.sv =====
module gme_back
  import gme_pkg::*;
#(
  parameter int MAX_ORDER    = DEF_MAX_ORDER,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH,
  localparam int OW    = $clog2(MAX_ORDER + 1),
  localparam int CW    = $clog2(MAX_CHANNELS + 1),
  localparam int OFS_W = $clog2(MAX_ORDER * (MAX_WIDTH + 1) * MAX_CHANNELS + 1) + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  cmd_t                    cmd_i,
  output logic                    cmd_pop_o,
  input  op_mode_e                op_i,
  input  logic [OW-1:0]           order_i,
  input  logic [CW-1:0]           chans_i,
  input  logic [CNT_W-1:0]        total_i,
  input  logic [OFS_W-1:0]        prime_i,
  input  logic signed [OFS_W-1:0] ro_i [MAX_ORDER],
  input  logic signed [OFS_W-1:0] to_i [MAX_ORDER][MAX_ORDER],
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BYTE_W-1:0]       result_byte_o,
  output logic                    last_byte_o
);

  localparam int SW = ((CNT_W > OFS_W) ? CNT_W : OFS_W) + 2;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int L  = (MAX_ORDER - 1) * MAX_CHANNELS + 1;
  localparam int LW = (L > 1) ? $clog2(L) : 1;

  logic                  en, issue, hit, pop;
  logic                  e_vld_q, e_vld_d, e_last_q, e_last_d;
  logic [CNT_W-1:0]      e_x_q, e_x_d;
  logic signed [SW-1:0]  rp_q, rp_d, x_s;

  logic [BYTE_W-1:0]     rdata [MAX_ORDER];
  logic [MAX_ORDER-1:0][MAX_ORDER-1:0] m0_d, m0_q, m1_q;
  logic                  rd_vld_q, rd_out_q, rd_last_q;
  logic                  v1_q, last1_q, v2_q, last2_q;
  logic [BYTE_W-1:0]     sr_q [MAX_ORDER][L];
  logic [BYTE_W-1:0]     row_d [MAX_ORDER];
  logic [BYTE_W-1:0]     row_q [MAX_ORDER];
  logic [BYTE_W-1:0]     res_d, res_q;
  logic                  out_vld_q, out_last_q;

  assign en = !(out_vld_q && out_stall_i);

  // window sequencer: issues row reads up to each result, priming the row shift registers at the start of an image
  always_comb begin
    x_s      = $signed({{(SW - CNT_W){1'b0}}, e_x_q});
    hit      = e_vld_q && (rp_q == x_s);
    issue    = en && e_vld_q;
    pop      = cmd_valid_i && en && (!e_vld_q || hit);
    e_vld_d  = e_vld_q;
    e_x_d    = e_x_q;
    e_last_d = e_last_q;
    rp_d     = rp_q;
    if (issue && !hit) begin
      rp_d = rp_q + 1'b1;
    end
    if (issue && hit) begin
      e_vld_d = 1'b0;
    end
    if (pop && cmd_i.emit) begin
      e_vld_d  = 1'b1;
      e_x_d    = cmd_i.xpos;
      e_last_d = cmd_i.last;
      rp_d     = (cmd_i.xpos == '0) ? -$signed({{(SW - OFS_W){1'b0}}, prime_i})
                                    : $signed({{(SW - CNT_W){1'b0}}, cmd_i.xpos});
    end
  end

  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      rp_q    <= '0;
    end else begin
      e_vld_q <= e_vld_d;
      rp_q    <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_x_q    <= e_x_d;
    e_last_q <= e_last_d;
  end

  // one copy of the byte store per window row, each read once a cycle while reads are issued
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_row
    logic [BYTE_W-1:0]    row_mem_q [STORE_DEPTH];
    logic [BYTE_W-1:0]    rd_q;
    logic signed [SW-1:0] raddr;

    assign raddr    = rp_q + SW'(ro_i[k]);
    assign rdata[k] = rd_q;

    always_ff @(posedge clk_i) begin
      if (pop && cmd_i.wr) begin
        row_mem_q[cmd_i.wpos[AW-1:0]] <= cmd_i.data;
      end
      if (issue) begin
        rd_q <= row_mem_q[raddr[AW-1:0]];
      end
    end
  end

  // bounds mask for every tap of the window
  always_comb begin
    logic signed [SW-1:0] n;
    for (int k = 0; k < MAX_ORDER; k++) begin
      for (int j = 0; j < MAX_ORDER; j++) begin
        n = rp_q + SW'(to_i[k][j]);
        m0_d[k][j] = !n[SW-1] && (n < $signed({{(SW - CNT_W){1'b0}}, total_i}))
                     && (k < int'(order_i)) && (j < int'(order_i));
      end
    end
  end

  always_comb begin
    logic [BYTE_W-1:0] acc;
    for (int k = 0; k < MAX_ORDER; k++) begin
      acc = morph_ident(op_i);
      for (int j = 0; j < MAX_ORDER; j++) begin
        if (m1_q[k][j]) begin
          acc = morph_pick(op_i, acc, sr_q[k][LW'(j * int'(chans_i))]);
        end
      end
      row_d[k] = acc;
    end
    res_d = morph_ident(op_i);
    for (int k = 0; k < MAX_ORDER; k++) begin
      res_d = morph_pick(op_i, res_d, row_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_out_q  <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      rd_vld_q  <= issue;
      rd_out_q  <= hit;
      v1_q      <= rd_vld_q && rd_out_q;
      v2_q      <= v1_q;
      out_vld_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_q       <= m0_d;
      rd_last_q  <= e_last_q;
      m1_q       <= m0_q;
      last1_q    <= rd_last_q;
      row_q      <= row_d;
      last2_q    <= last1_q;
      res_q      <= res_d;
      out_last_q <= last2_q;
      if (rd_vld_q) begin
        for (int k = 0; k < MAX_ORDER; k++) begin
          for (int m = L - 1; m > 0; m--) begin
            sr_q[k][m] <= sr_q[k][m-1];
          end
          sr_q[k][0] <= rdata[k];
        end
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_byte_o = res_q;
  assign last_byte_o   = out_last_q;

endmodule

// ===== design/gray_morph_erode_dilate.sv =====
// Streaming grayscale erosion/dilation over a flat square window. Image bytes
// enter one beat per cycle unless stalled, in raster and channel order; pad
// beats carry no byte and only flush the results still owed at the end of an
// image. The front keeps the byte and result counters and decides per beat
// whether a result is due; the back stores bytes in one memory copy per window
// row and reads all rows at once into per-row shift registers, so a result
// can leave every cycle once the pipeline is primed, unless the output stalls.
// Results trail the input by (window_size/2)*(image_width+1)*channel_count
// bytes and then pass the memory read, shift registers and row and final
// reductions. Before the first result of each image the back issues
// (window_size-1)*channel_count extra reads to fill the row shift registers;
// once the four-entry queue between front and back fills, the input stalls
// until that priming ends. After reset and after every register write the input
// stalls while the derived offsets settle; write registers only while idle.
module gray_morph_erode_dilate
  import gme_pkg::*;
#(
  parameter int MAX_ORDER    = DEF_MAX_ORDER,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_BYTES    = DEF_MAX_BYTES,
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [BYTE_W-1:0]     sample_i,
  input  logic                  pad_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BYTE_W-1:0]     result_byte_o,
  output logic                  last_byte_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int CW    = $clog2(MAX_CHANNELS + 1);
  localparam int OFS_W = $clog2(MAX_ORDER * (MAX_WIDTH + 1) * MAX_CHANNELS + 1) + 1;

  op_mode_e                op;
  logic [OW-1:0]           order;
  logic [CW-1:0]           chans;
  logic [CNT_W-1:0]        total;
  logic [OFS_W-1:0]        look;
  logic [OFS_W-1:0]        prime;
  logic signed [OFS_W-1:0] ro [MAX_ORDER];
  logic signed [OFS_W-1:0] to [MAX_ORDER][MAX_ORDER];
  logic                    cfg_busy;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t f_cmd, q_cmd;

  gme_cfg #(
    .MAX_ORDER   (MAX_ORDER),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_BYTES   (MAX_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (cfg_busy),
    .op_o       (op),
    .order_o    (order),
    .chans_o    (chans),
    .total_o    (total),
    .look_o     (look),
    .prime_o    (prime),
    .ro_o       (ro),
    .to_o       (to)
  );

  gme_front #(
    .MAX_ORDER   (MAX_ORDER),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .pad_i       (pad_i),
    .total_i     (total),
    .look_i      (look),
    .cfg_busy_i  (cfg_busy),
    .queue_full_i(q_full),
    .cmd_push_o  (q_push),
    .cmd_o       (f_cmd)
  );

  gme_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (f_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_cmd)
  );

  gme_back #(
    .MAX_ORDER   (MAX_ORDER),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (q_pop),
    .op_i         (op),
    .order_i      (order),
    .chans_i      (chans),
    .total_i      (total),
    .prime_i      (prime),
    .ro_i         (ro),
    .to_i         (to),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_byte_o(result_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule
